// ----- sv/scfla_pkg.sv -----
// Shared types, constants and the carving table of the size-class free-list allocator.
// Used by the stack memory filler and by the top level; depends on nothing.
package scfla_pkg;

  // Geometry of the class stacks.
  localparam int MIN_CLASS   = 0;
  localparam int MAX_CLASS   = 30;
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_BITS   = 30;
  localparam int NUM_CLASSES = 32;
  localparam int CLS_W       = 5;
  localparam int TABLE_LEN   = 30;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int MEM_AW      = CLS_W + IDX_W;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OOM  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Number of blocks carved at reset for each class.
  localparam int CARVE_TABLE [TABLE_LEN] = '{
    0,  0,  0,  0,  0,  0,  0, 64, 64, 64,
    32, 32, 32, 16, 16, 16, 16,  8,  8,  8,
    8,  8,  8,  8,  4,  4,  2,  2,  0,  0
  };

  // Input item.
  typedef struct packed {
    logic        mode;
    logic [29:0] req_bytes;
    logic [29:0] free_addr;
    logic [4:0]  free_class;
  } alloc_req_t;

  // Result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [29:0] block_addr;
    logic [4:0]  block_class;
  } alloc_res_t;

  // One write access to the stack memory.
  typedef struct packed {
    logic                 en;
    logic [MEM_AW-1:0]    addr;
    logic [ADDR_BITS-1:0] data;
  } mem_wr_t;

  // Blocks carved for a class at reset, limited to the stack depth.
  function automatic int carve_count(input int cls);
    int cnt;
    cnt = 0;
    if (cls >= MIN_CLASS && cls < MAX_CLASS && cls < TABLE_LEN) begin
      cnt = CARVE_TABLE[cls];
      if (cnt > STACK_DEPTH) begin
        cnt = STACK_DEPTH;
      end
    end
    return cnt;
  endfunction

endpackage

// ----- sv/size_class_free_list_allocator.sv -----
// Top level of the size-class free-list allocator: request stage, stack counts and results.
// Depends on scfla_pkg, scfla_stack_ram and scfla_fill.
//
// After reset the block carves its initial free blocks into the stack memory, one block per
// cycle except when it moves on to the next class; busy stays high meanwhile.
// Afterwards each item is first registered together with its rounded size class; then
// the non-empty flags are searched and the single access to the stack memory is made.
// The result is shown for one cycle on res_o with res_valid_o high, in the
// cycle after the memory access, and must be taken then: nothing holds it. A new item may
// be started in that same cycle.
module size_class_free_list_allocator
  import scfla_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  alloc_req_t in_i,
  output logic       res_valid_o,
  output alloc_res_t res_o
);

  logic                 accept;
  logic                 fill_active;
  mem_wr_t              fill_wr;

  logic                 req_valid_q;
  logic                 req_mode_q;
  logic [CLS_W-1:0]     req_cls_q;
  logic [ADDR_BITS-1:0] req_addr_q;
  logic [CLS_W-1:0]     req_fclass_q;
  logic [CLS_W-1:0]     start_cls;

  logic [CNT_W-1:0]     counts_q [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] cand;
  logic                 hit;
  logic [CLS_W-1:0]     found;
  logic [CNT_W-1:0]     top_idx;
  logic [CNT_W-1:0]     fcount;
  logic                 free_ok;
  logic                 do_pop;
  logic                 do_push;

  logic                 res_valid_q;
  logic [1:0]           res_status_q;
  logic [CLS_W-1:0]     res_class_q;
  logic                 res_from_mem_q;

  logic                 ram_we;
  logic [MEM_AW-1:0]    ram_waddr;
  logic [ADDR_BITS-1:0] ram_wdata;
  logic [MEM_AW-1:0]    ram_raddr;
  logic [ADDR_BITS-1:0] ram_rdata;

  // Smallest e with 2^e >= n, zero for n of zero or one.
  function automatic logic [CLS_W-1:0] ceil_log2(input logic [29:0] n);
    logic [29:0]      m;
    logic [CLS_W-1:0] e;
    m = n - 30'd1;
    e = '0;
    if (n > 30'd1) begin
      for (int i = 0; i < 30; i++) begin
        if (m[i]) begin
          e = CLS_W'(i + 1);
        end
      end
    end
    return e;
  endfunction

  assign busy   = fill_active || req_valid_q;
  assign accept = start && !busy;

  // Starting class of an allocation: rounded exponent plus one, clamped.
  always_comb begin
    logic [CLS_W:0] cls;
    cls = {1'b0, ceil_log2(in_i.req_bytes)} + (CLS_W + 1)'(1);
    if (int'(cls) < MIN_CLASS) begin
      cls = (CLS_W + 1)'(MIN_CLASS);
    end
    if (int'(cls) > MAX_CLASS) begin
      cls = (CLS_W + 1)'(MAX_CLASS);
    end
    start_cls = cls[CLS_W-1:0];
  end

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_mode_q   <= in_i.mode;
      req_cls_q    <= start_cls;
      req_addr_q   <= in_i.free_addr;
      req_fclass_q <= in_i.free_class;
    end
  end

  // Upward search for the lowest non-empty stack at or above the starting class.
  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cand[i] = (counts_q[i] != '0) && (i >= int'(req_cls_q)) && (i <= MAX_CLASS);
    end
    hit   = |cand;
    found = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = CLS_W'(i);
      end
    end
  end

  assign top_idx = counts_q[found] - CNT_W'(1);
  assign fcount  = counts_q[req_fclass_q];
  assign free_ok = (int'(req_fclass_q) <= MAX_CLASS) && (int'(fcount) < STACK_DEPTH);
  assign do_pop  = req_valid_q && (req_mode_q == MODE_ALLOC) && hit;
  assign do_push = req_valid_q && (req_mode_q == MODE_FREE) && free_ok;

  // Stack fill counts, loaded from the carving table at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts_q[i] <= CNT_W'(carve_count(i));
      end
    end else if (do_pop) begin
      counts_q[found] <= top_idx;
    end else if (do_push) begin
      counts_q[req_fclass_q] <= fcount + CNT_W'(1);
    end
  end

  // Result registers; the popped offset arrives from the memory in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      res_from_mem_q <= do_pop;
      res_class_q    <= do_pop ? found : '0;
      if (req_mode_q == MODE_ALLOC) begin
        res_status_q <= hit ? STATUS_OK : STATUS_OOM;
      end else begin
        res_status_q <= free_ok ? STATUS_OK : STATUS_FULL;
      end
    end
  end

  // Memory port sharing: the filler owns the write port until it finishes.
  always_comb begin
    if (fill_active) begin
      ram_we    = fill_wr.en;
      ram_waddr = fill_wr.addr;
      ram_wdata = fill_wr.data;
    end else begin
      ram_we    = do_push;
      ram_waddr = {req_fclass_q, fcount[IDX_W-1:0]};
      ram_wdata = req_addr_q;
    end
    ram_raddr = {found, top_idx[IDX_W-1:0]};
  end

  scfla_fill u_fill (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .active_o (fill_active),
    .wr_o     (fill_wr)
  );

  scfla_stack_ram #(
    .AW (MEM_AW),
    .DW (ADDR_BITS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (do_pop),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result ports.
  always_comb begin
    res_o.status      = res_status_q;
    res_o.block_addr  = res_from_mem_q ? ram_rdata : '0;
    res_o.block_class = res_class_q;
  end

  assign res_valid_o = res_valid_q;

`ifndef SYNTHESIS
  // A result appears only in the cycle after its request was processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(req_valid_q))
    else $error("result without a processed request");

  // Requests are never processed while the memory is still being carved.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fill_active && req_valid_q))
    else $error("request processed during the initial fill");

  // Only a successful allocation reports an address or a class.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status != STATUS_OK) |->
      (res_o.block_addr == '0) && (res_o.block_class == '0))
    else $error("failed request reports an address or class");

  // An accepted item is followed by its result, through the request register and the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 res_valid_o)
    else $error("accepted item produced no result");
`endif

endmodule

// ----- sv/scfla_stack_ram.sv -----
// Simple dual-port synchronous RAM holding the class stacks.
// One write port, one read port with registered read data; no dependencies.
module scfla_stack_ram #(
  parameter int AW = 11,
  parameter int DW = 30
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data, loaded only while re_i is high.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/scfla_fill.sv -----
// Reset-time sequencer that carves consecutive block offsets into the class stacks.
// Depends on scfla_pkg for the carving table and the memory write type.
module scfla_fill
  import scfla_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  output logic    active_o,
  output mem_wr_t wr_o
);

  logic                 active_q;
  logic [CLS_W-1:0]     cls_q;
  logic [CNT_W-1:0]     idx_q;
  logic [ADDR_BITS-1:0] tail_q;
  logic [CNT_W-1:0]     cnt;
  logic                 cls_done;
  logic                 in_class;

  // Blocks to carve for the current class.
  assign cnt      = CNT_W'(carve_count(int'(cls_q)));
  assign cls_done = (int'(cls_q) >= MAX_CLASS);
  assign in_class = (idx_q < cnt);

  // Walk the classes in ascending order, one block per cycle except when moving on to the next class.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      cls_q    <= CLS_W'(MIN_CLASS);
      idx_q    <= '0;
      tail_q   <= '0;
    end else if (active_q) begin
      if (cls_done) begin
        active_q <= 1'b0;
      end else if (in_class) begin
        idx_q  <= idx_q + CNT_W'(1);
        tail_q <= tail_q + (ADDR_BITS'(1) << cls_q);
      end else begin
        cls_q <= cls_q + CLS_W'(1);
        idx_q <= '0;
      end
    end
  end

  // The current offset goes to the current slot of the current class.
  always_comb begin
    wr_o.en   = active_q && !cls_done && in_class;
    wr_o.addr = {cls_q, idx_q[IDX_W-1:0]};
    wr_o.data = tail_q;
  end

  assign active_o = active_q;

endmodule
